@@ hdl/i2cmts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Event codes, sequencer state and result beat layout.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned RES_W     = 46;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_START_WRITE = 3'd0,
    OP_START_READ  = 3'd1,
    OP_START_SENT  = 3'd2,
    OP_ADDR_SENT   = 3'd3,
    OP_BYTE_RX     = 3'd4,
    OP_TX_EMPTY    = 3'd5
  } op_t;

  typedef struct packed {
    logic       buffer_events_on;
    logic       ack_on;
    logic [7:0] rx_position;
    logic [7:0] tx_position;
    logic [7:0] rx_left;
    logic [7:0] tx_left;
    logic [7:0] address_byte;
  } seq_state_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [7:0] bytes_remaining;
    logic       buffer_event_enable;
    logic       ack_enable;
    logic       stop_request;
    logic       start_request;
    logic [7:0] store_byte;
    logic [7:0] store_index;
    logic       store_valid;
    logic [7:0] tx_index;
    logic [7:0] send_byte;
    logic       send_valid;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/i2c_master_transfer_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Steps one I2C master transfer per bus controller event beat.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its event beat is accepted.
// One event per cycle while the result beat is not stalled; the result register frees as it is taken.
// The per-event decode and count update sit between input and result register.
// Reset (rst, synchronous): counts, positions and address clear, acknowledge
// on, buffer events off, no result pending.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: slave_address[6:0], transfer_count[14:7], data_byte[22:15], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[2:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: send_valid, send_byte, tx_index, store_valid, store_index, store_byte,
  // start_request, stop_request, ack_enable, buffer_event_enable,
  // bytes_remaining, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  seq_state_t st;
  seq_state_t st_next;
  result_t    res;
  result_t    res_next;
  logic       in_accept;
  op_t        opcode;
  logic [6:0] slave_address;
  logic [7:0] transfer_count;
  logic [7:0] data_byte;
  logic [7:0] rx_dec;

  assign opcode         = op_t'(s_axis_tuser);
  assign slave_address  = s_axis_tdata[6:0];
  assign transfer_count = s_axis_tdata[14:7];
  assign data_byte      = s_axis_tdata[22:15];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, res};

  assign rx_dec = (st.rx_left != 8'd0) ? st.rx_left - 8'd1 : 8'd0;

  always_comb begin
    st_next  = st;
    res_next = '0;
    unique case (opcode)
      OP_START_WRITE: begin
        st_next.tx_left      = transfer_count;
        st_next.tx_position  = 8'd0;
        st_next.address_byte = {slave_address, 1'b0};
        st_next.ack_on       = 1'b1;
        res_next.start_request = 1'b1;
      end
      OP_START_READ: begin
        st_next.rx_left      = transfer_count;
        st_next.rx_position  = 8'd0;
        st_next.address_byte = {slave_address, 1'b1};
        st_next.ack_on       = 1'b1;
        res_next.start_request = 1'b1;
      end
      OP_START_SENT: begin
        res_next.send_valid = 1'b1;
        res_next.send_byte  = st.address_byte;
      end
      OP_ADDR_SENT: begin
        st_next.buffer_events_on = 1'b1;
        if (st.address_byte[0]) begin
          if (st.rx_left == 8'd1) begin
            st_next.ack_on        = 1'b0;
            res_next.stop_request = 1'b1;
          end
        end else begin
          res_next.send_valid = 1'b1;
          res_next.send_byte  = data_byte;
          res_next.tx_index   = st.tx_position;
          st_next.tx_position = st.tx_position + 8'd1;
          st_next.tx_left     = (st.tx_left != 8'd0) ? st.tx_left - 8'd1 : 8'd0;
        end
      end
      OP_BYTE_RX: begin
        res_next.store_valid = 1'b1;
        res_next.store_index = st.rx_position;
        res_next.store_byte  = data_byte;
        st_next.rx_position  = st.rx_position + 8'd1;
        st_next.rx_left      = rx_dec;
        if (rx_dec == 8'd1) begin
          st_next.ack_on        = 1'b0;
          res_next.stop_request = 1'b1;
        end else if (rx_dec == 8'd0) begin
          st_next.ack_on           = 1'b1;
          st_next.buffer_events_on = 1'b0;
        end
      end
      OP_TX_EMPTY: begin
        if (st.tx_left == 8'd0) begin
          res_next.stop_request    = 1'b1;
          st_next.buffer_events_on = 1'b0;
        end else begin
          res_next.send_valid = 1'b1;
          res_next.send_byte  = data_byte;
          res_next.tx_index   = st.tx_position;
          st_next.tx_position = st.tx_position + 8'd1;
          st_next.tx_left     = st.tx_left - 8'd1;
        end
      end
      default: begin
      end
    endcase
    res_next.ack_enable          = st_next.ack_on;
    res_next.buffer_event_enable = st_next.buffer_events_on;
    res_next.bytes_remaining     = st_next.address_byte[0] ? st_next.rx_left
                                                           : st_next.tx_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{buffer_events_on: 1'b0,
              ack_on:           1'b1,
              rx_position:      8'd0,
              tx_position:      8'd0,
              rx_left:          8'd0,
              tx_left:          8'd0,
              address_byte:     8'd0};
      m_axis_tvalid       <= 1'b0;
    end else begin
      if (in_accept) begin
        st            <= st_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result beat stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted event produced no result beat");

  a_start_stop_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.start_request && res.stop_request))
    else $error("start and stop requested in one beat");

  a_send_store_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.send_valid && res.store_valid))
    else $error("send and store in one beat");
`endif

endmodule
`default_nettype wire
